>>> design/gdcr_pkg.sv
// Package for the grid DDA column ray caster.
// Holds fixed-point constants, register indexes, colors, the sequencer state type
// and small helper functions. Depends on nothing.
`default_nettype none
package gdcr_pkg;

    localparam int C_FRAC_BITS     = 16;
    localparam int C_MAP_SIZE      = 32;
    localparam int C_SCREEN_WIDTH  = 800;
    localparam int C_SCREEN_HEIGHT = 800;

    localparam int C_POS_W = 21;
    localparam int C_VEC_W = 18;
    localparam int C_CFG_W = 21;
    localparam int C_IDX_W = 3;

    localparam logic [C_IDX_W-1:0] C_REG_POS_X   = 3'd0;
    localparam logic [C_IDX_W-1:0] C_REG_POS_Y   = 3'd1;
    localparam logic [C_IDX_W-1:0] C_REG_DIR_X   = 3'd2;
    localparam logic [C_IDX_W-1:0] C_REG_DIR_Y   = 3'd3;
    localparam logic [C_IDX_W-1:0] C_REG_PLANE_X = 3'd4;
    localparam logic [C_IDX_W-1:0] C_REG_PLANE_Y = 3'd5;

    localparam logic [C_POS_W-1:0] C_RST_POS_X   = 21'd786432;
    localparam logic [C_POS_W-1:0] C_RST_POS_Y   = 21'd327680;
    localparam logic [C_VEC_W-1:0] C_RST_DIR_X   = 18'h30000;
    localparam logic [C_VEC_W-1:0] C_RST_DIR_Y   = 18'h00000;
    localparam logic [C_VEC_W-1:0] C_RST_PLANE_X = 18'h00000;
    localparam logic [C_VEC_W-1:0] C_RST_PLANE_Y = 18'd43253;

    localparam logic C_CMD_WRITE = 1'b0;
    localparam logic C_CMD_CAST  = 1'b1;

    localparam logic [23:0] C_COLOR_RED    = 24'hFF0000;
    localparam logic [23:0] C_COLOR_GREEN  = 24'h00FF00;
    localparam logic [23:0] C_COLOR_BLUE   = 24'h0000FF;
    localparam logic [23:0] C_COLOR_WHITE  = 24'hFFFFFF;
    localparam logic [23:0] C_COLOR_YELLOW = 24'hFFFF00;

    localparam logic [2:0] C_KIND_RED   = 3'd1;
    localparam logic [2:0] C_KIND_GREEN = 3'd2;
    localparam logic [2:0] C_KIND_BLUE  = 3'd3;
    localparam logic [2:0] C_KIND_WHITE = 3'd4;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CAM, S_RAY_MUL, S_RAY_ADD,
        S_DX, S_DX_W, S_DY, S_DY_W, S_SIDE, S_CHECK, S_STEP, S_TEST,
        S_NUM, S_DIST, S_DIST_W, S_LH, S_LH_W, S_OUT
    } t_state;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [23:0] kind_color(input logic [2:0] kind);
        logic [23:0] c;
        case (kind)
            C_KIND_RED:   c = C_COLOR_RED;
            C_KIND_GREEN: c = C_COLOR_GREEN;
            C_KIND_BLUE:  c = C_COLOR_BLUE;
            C_KIND_WHITE: c = C_COLOR_WHITE;
            default:      c = C_COLOR_YELLOW;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> design/grid_dda_column_raycaster.sv
// Channel   Direction  Handshake                    Payload
// command   in         start & !busy                i_cmd, i_cell_x/y, i_cell_kind, i_column
// result    out        o_valid, one cycle, no stall o_out_column ... o_left_map
// config    in         i_cfg_we                     i_cfg_index, i_cfg_data
//
// A cell write is taken in the idle state and leaves busy low. A cast runs up to four
// serial divisions (40 quotient bits each at the default sizes; a zero ray component skips
// its one) and passes through a step state and a test state, with one map memory read, per
// grid cell visited (at most 66 cells); the result strobe is registered from the output state.
// After reset the map memory is cleared one cell per cycle, all MAP_SIZE*MAP_SIZE cells
// (1024 by default), with busy high. Results cannot be stalled by the receiver.
`default_nettype none
module grid_dda_column_raycaster #(
    parameter int MAP_SIZE      = gdcr_pkg::C_MAP_SIZE,
    parameter int SCREEN_WIDTH  = gdcr_pkg::C_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = gdcr_pkg::C_SCREEN_HEIGHT
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_cmd,
    input  wire logic [4:0]                   i_cell_x,
    input  wire logic [4:0]                   i_cell_y,
    input  wire logic [2:0]                   i_cell_kind,
    input  wire logic [9:0]                   i_column,
    input  wire logic                         i_cfg_we,
    input  wire logic [gdcr_pkg::C_IDX_W-1:0] i_cfg_index,
    input  wire logic [gdcr_pkg::C_CFG_W-1:0] i_cfg_data,
    output logic                              o_valid,
    output logic      [9:0]                   o_out_column,
    output logic      [9:0]                   o_draw_start,
    output logic      [9:0]                   o_draw_end,
    output logic      [23:0]                  o_wall_color,
    output logic                              o_hit_side,
    output logic      [2:0]                   o_hit_kind,
    output logic      [31:0]                  o_wall_distance,
    output logic                              o_left_map
);
    import gdcr_pkg::*;

    localparam int F       = C_FRAC_BITS;
    localparam int DEPTH   = MAP_SIZE * MAP_SIZE;
    localparam int AW      = $clog2(DEPTH);
    localparam int MC_W    = max_int($clog2(MAP_SIZE), C_POS_W - F) + 2;
    localparam int CAMQ_W  = 11 + F;
    localparam int CAM_W   = CAMQ_W + 1;
    localparam int CAM_SH  = 20;
    localparam int CR_W    = F + 18;
    localparam int PR_W    = C_VEC_W + CAM_W;
    localparam int RAY_W   = PR_W - F + 1;
    localparam int NM_W    = MC_W + F + 1;
    localparam int DN_W    = max_int(max_int(NM_W + F, 2 * F + 1), 11 + F);
    localparam int DEN_W   = max_int(32, RAY_W);
    localparam int DL_W    = 2 * F + 1;
    localparam int SD_W    = DL_W + $clog2(2 * MAP_SIZE + 3) + 1;
    localparam int CNT_W   = $clog2(2 * MAP_SIZE + 2);
    localparam int LH_W    = $clog2(4 * SCREEN_HEIGHT + 1) + 1;

    localparam logic signed [MC_W-1:0] C_MAP_LIM = MC_W'(MAP_SIZE);
    localparam logic [CAM_W-1:0]       C_ONE_CAM = CAM_W'(64'd1 << F);
    localparam logic [CR_W-1:0]        C_CAM_RECIP =
        CR_W'(((64'd1 << (F + 1 + CAM_SH)) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));
    localparam logic [NM_W-1:0]        C_ONE_NM  = NM_W'(64'd1 << F);
    localparam logic [F:0]             C_ONE_F   = (F + 1)'(64'd1 << F);
    localparam logic [CNT_W-1:0]       C_CNT_END = CNT_W'(2 * MAP_SIZE + 1);
    localparam logic [LH_W-1:0]        C_LH_MAX  = LH_W'(4 * SCREEN_HEIGHT);
    localparam logic [LH_W-1:0]        C_HALF    = LH_W'(SCREEN_HEIGHT / 2);
    localparam logic [LH_W-1:0]        C_H_LAST  = LH_W'(SCREEN_HEIGHT - 1);

    t_state r_state, n_state;

    logic [C_POS_W-1:0] r_pos_x, r_pos_y;
    logic signed [C_VEC_W-1:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;

    logic [9:0]               r_column;
    logic signed [CAM_W-1:0]  r_cam;
    logic signed [PR_W-1:0]   r_prod_x, r_prod_y;
    logic signed [RAY_W-1:0]  r_ray_x, r_ray_y;
    logic [DL_W-1:0]          r_delta_x, r_delta_y;
    logic                     r_inf_x, r_inf_y;
    logic [SD_W-1:0]          r_sd_x, r_sd_y;
    logic signed [MC_W-1:0]   r_map_x, r_map_y;
    logic                     r_side, r_left;
    logic [2:0]               r_kind;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [NM_W-1:0]   r_num;
    logic [31:0]              r_dist;
    logic [LH_W-1:0]          r_lh;
    logic [AW-1:0]            r_clr;

    logic            accept;
    logic            cell_in;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [2:0]      mem_wdata, mem_rdata;
    logic            div_start, div_done;
    logic [DN_W-1:0] div_num, div_q;
    logic [DEN_W-1:0] div_den;

    logic [CR_W+9:0]  cam_prod;
    logic [RAY_W-1:0] mag_x, mag_y, mag_s;
    logic signed [PR_W-1:0] sh_x, sh_y;
    logic [F:0]       f_x, f_y;
    logic [DL_W+F:0]  sp_x, sp_y;
    logic             lt, step_side;
    logic signed [MC_W-1:0] nx, ny;
    logic             step_out, init_out;
    logic signed [RAY_W-1:0] ray_s;
    logic signed [MC_W-1:0]  map_s;
    logic [C_POS_W-1:0]      pos_s;
    logic signed [NM_W-1:0]  num_c;
    logic [NM_W-1:0]         num_mag;
    logic                    dist_zero_ray, dist_bad;
    logic [LH_W-1:0]         ceil_half, floor_half, ds_c, de_c;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign cell_in = (32'(i_cell_x) < 32'(MAP_SIZE)) && (32'(i_cell_y) < 32'(MAP_SIZE));

    // The camera quotient is exact for every 10-bit column through the rounded-up reciprocal.
    assign cam_prod = r_column * C_CAM_RECIP;

    // Datapath helpers.
    assign mag_x = r_ray_x[RAY_W-1] ? RAY_W'(-r_ray_x) : RAY_W'(r_ray_x);
    assign mag_y = r_ray_y[RAY_W-1] ? RAY_W'(-r_ray_y) : RAY_W'(r_ray_y);
    assign sh_x  = r_prod_x >>> F;
    assign sh_y  = r_prod_y >>> F;
    assign f_x   = r_ray_x[RAY_W-1] ? {1'b0, r_pos_x[F-1:0]} : C_ONE_F - {1'b0, r_pos_x[F-1:0]};
    assign f_y   = r_ray_y[RAY_W-1] ? {1'b0, r_pos_y[F-1:0]} : C_ONE_F - {1'b0, r_pos_y[F-1:0]};
    assign sp_x  = r_delta_x * f_x;
    assign sp_y  = r_delta_y * f_y;

    assign lt        = r_inf_x ? 1'b0 : (r_inf_y ? 1'b1 : (r_sd_x < r_sd_y));
    assign step_side = !lt;
    assign nx = (step_side == 1'b0) ? (r_ray_x[RAY_W-1] ? r_map_x - 1'b1 : r_map_x + 1'b1)
                                    : r_map_x;
    assign ny = (step_side == 1'b1) ? (r_ray_y[RAY_W-1] ? r_map_y - 1'b1 : r_map_y + 1'b1)
                                    : r_map_y;
    assign step_out = nx[MC_W-1] || ny[MC_W-1] || (nx >= C_MAP_LIM) || (ny >= C_MAP_LIM);
    assign init_out = (r_map_x >= C_MAP_LIM) || (r_map_y >= C_MAP_LIM);

    assign ray_s   = r_side ? r_ray_y : r_ray_x;
    assign mag_s   = r_side ? mag_y : mag_x;
    assign map_s   = r_side ? r_map_y : r_map_x;
    assign pos_s   = r_side ? r_pos_y : r_pos_x;
    assign num_c   = $signed({map_s[MC_W-1], map_s, {F{1'b0}}})
                   - $signed({{(NM_W-C_POS_W){1'b0}}, pos_s})
                   + $signed(ray_s[RAY_W-1] ? C_ONE_NM : NM_W'(0));
    assign num_mag = r_num[NM_W-1] ? NM_W'(-r_num) : NM_W'(r_num);
    assign dist_zero_ray = (ray_s == '0);
    assign dist_bad      = (r_num == '0) || (r_num[NM_W-1] != ray_s[RAY_W-1]);

    assign ceil_half  = (r_lh + 1'b1) >> 1;
    assign floor_half = r_lh >> 1;
    assign ds_c = (ceil_half >= C_HALF) ? '0 : C_HALF - ceil_half;
    assign de_c = (C_HALF + floor_half > C_H_LAST) ? C_H_LAST : C_HALF + floor_half;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:   if (r_clr == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:    if (accept && i_cmd == C_CMD_CAST) n_state = S_CAM;
            S_CAM:     n_state = S_RAY_MUL;
            S_RAY_MUL: n_state = S_RAY_ADD;
            S_RAY_ADD: n_state = S_DX;
            S_DX:      n_state = (r_ray_x == '0) ? S_DY : S_DX_W;
            S_DX_W:    if (div_done) n_state = S_DY;
            S_DY:      n_state = (r_ray_y == '0) ? S_SIDE : S_DY_W;
            S_DY_W:    if (div_done) n_state = S_SIDE;
            S_SIDE:    n_state = S_CHECK;
            S_CHECK:   n_state = init_out ? S_LH : S_STEP;
            S_STEP:    n_state = step_out ? S_NUM : S_TEST;
            S_TEST: begin
                if (mem_rdata != 3'd0 || r_cnt == C_CNT_END) begin
                    n_state = S_NUM;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_NUM:     n_state = S_DIST;
            S_DIST:    n_state = (dist_zero_ray || dist_bad) ? S_LH : S_DIST_W;
            S_DIST_W:  if (div_done) n_state = S_LH;
            S_LH:      n_state = (r_dist == '0) ? S_OUT : S_LH_W;
            S_LH_W:    if (div_done) n_state = S_OUT;
            S_OUT:     n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Control outputs: divider requests and map memory port.
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (r_state)
            S_DX: begin
                div_start = (r_ray_x != '0);
                div_num   = DN_W'(DL_W'(1) << (2 * F));
                div_den   = DEN_W'(mag_x);
            end
            S_DY: begin
                div_start = (r_ray_y != '0);
                div_num   = DN_W'(DL_W'(1) << (2 * F));
                div_den   = DEN_W'(mag_y);
            end
            S_DIST: begin
                div_start = !(dist_zero_ray || dist_bad);
                div_num   = DN_W'({num_mag, {F{1'b0}}});
                div_den   = DEN_W'(mag_s);
            end
            S_LH: begin
                div_start = (r_dist != '0);
                div_num   = DN_W'({11'(SCREEN_HEIGHT), {F{1'b0}}});
                div_den   = DEN_W'(r_dist);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = AW'(AW'(i_cell_x) * AW'(MAP_SIZE) + AW'(i_cell_y));
        mem_wdata = i_cell_kind;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = 3'd0;
        end else if (accept && i_cmd == C_CMD_WRITE && cell_in) begin
            mem_we = 1'b1;
        end
    end

    assign mem_raddr = AW'(AW'(nx) * AW'(MAP_SIZE) + AW'(ny));

    gdcr_map_mem #(.DEPTH(DEPTH), .AW(AW)) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    gdcr_div #(.N_W(DN_W), .D_W(DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            o_valid   <= 1'b0;
            r_pos_x   <= C_RST_POS_X;
            r_pos_y   <= C_RST_POS_Y;
            r_dir_x   <= C_RST_DIR_X;
            r_dir_y   <= C_RST_DIR_Y;
            r_plane_x <= C_RST_PLANE_X;
            r_plane_y <= C_RST_PLANE_Y;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == S_OUT);
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    C_REG_POS_X:   r_pos_x   <= i_cfg_data;
                    C_REG_POS_Y:   r_pos_y   <= i_cfg_data;
                    C_REG_DIR_X:   r_dir_x   <= i_cfg_data[C_VEC_W-1:0];
                    C_REG_DIR_Y:   r_dir_y   <= i_cfg_data[C_VEC_W-1:0];
                    C_REG_PLANE_X: r_plane_x <= i_cfg_data[C_VEC_W-1:0];
                    C_REG_PLANE_Y: r_plane_y <= i_cfg_data[C_VEC_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Cast datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_column <= i_column;
                r_kind   <= 3'd0;
                r_left   <= 1'b0;
                r_side   <= 1'b0;
                r_cnt    <= '0;
            end
            S_CAM: begin
                r_cam <= $signed({1'b0, CAMQ_W'(cam_prod >> CAM_SH)}) - $signed(C_ONE_CAM);
            end
            S_RAY_MUL: begin
                r_prod_x <= r_plane_x * r_cam;
                r_prod_y <= r_plane_y * r_cam;
            end
            S_RAY_ADD: begin
                r_ray_x <= $signed({{(RAY_W-C_VEC_W){r_dir_x[C_VEC_W-1]}}, r_dir_x})
                         + $signed(sh_x[RAY_W-1:0]);
                r_ray_y <= $signed({{(RAY_W-C_VEC_W){r_dir_y[C_VEC_W-1]}}, r_dir_y})
                         + $signed(sh_y[RAY_W-1:0]);
                r_map_x <= $signed(MC_W'(r_pos_x[C_POS_W-1:F]));
                r_map_y <= $signed(MC_W'(r_pos_y[C_POS_W-1:F]));
            end
            S_DX:   r_inf_x <= (r_ray_x == '0);
            S_DX_W: if (div_done) r_delta_x <= div_q[DL_W-1:0];
            S_DY:   r_inf_y <= (r_ray_y == '0);
            S_DY_W: if (div_done) r_delta_y <= div_q[DL_W-1:0];
            S_SIDE: begin
                r_sd_x <= SD_W'(sp_x >> F);
                r_sd_y <= SD_W'(sp_y >> F);
            end
            S_CHECK: begin
                if (init_out) begin
                    r_left <= 1'b1;
                    r_dist <= '0;
                end
            end
            S_STEP: begin
                r_side  <= step_side;
                r_map_x <= nx;
                r_map_y <= ny;
                if (step_side == 1'b0 && !r_inf_x) begin
                    r_sd_x <= r_sd_x + SD_W'(r_delta_x);
                end
                if (step_side == 1'b1 && !r_inf_y) begin
                    r_sd_y <= r_sd_y + SD_W'(r_delta_y);
                end
                if (step_out) begin
                    r_left <= 1'b1;
                end
            end
            S_TEST: begin
                r_kind <= mem_rdata;
                r_cnt  <= r_cnt + 1'b1;
            end
            S_NUM:  r_num <= num_c;
            S_DIST: begin
                if (dist_zero_ray) begin
                    r_dist <= 32'hFFFF_FFFF;
                end else if (dist_bad) begin
                    r_dist <= '0;
                end
            end
            S_DIST_W: begin
                if (div_done) begin
                    r_dist <= (|div_q[DN_W-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
                end
            end
            S_LH: if (r_dist == '0) r_lh <= C_LH_MAX;
            S_LH_W: begin
                if (div_done) begin
                    r_lh <= (div_q > DN_W'(C_LH_MAX)) ? C_LH_MAX : div_q[LH_W-1:0];
                end
            end
            S_OUT: begin
                o_out_column    <= r_column;
                o_draw_start    <= ds_c[9:0];
                o_draw_end      <= de_c[9:0];
                o_hit_side      <= r_side;
                o_hit_kind      <= r_left ? 3'd0 : r_kind;
                o_wall_color    <= r_left ? 24'd0 :
                                   (r_side ? (kind_color(r_kind) >> 1) : kind_color(r_kind));
                o_wall_distance <= r_dist;
                o_left_map      <= r_left;
            end
            default: ;
        endcase
    end

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held for two cycles");
    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == C_CMD_WRITE) |=> !busy) else $error("cell write kept block busy");
    a_left_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_left_map) |-> (o_hit_kind == 3'd0 && o_wall_color == 24'd0))
        else $error("ray that left the map reports a wall");
    a_slice_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_draw_start <= o_draw_end)) else $error("slice start after end");
    a_no_cast_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (busy && !div_start)) else $error("work during map clear");
endmodule
`default_nettype wire

>>> design/gdcr_map_mem.sv
// Grid map store: one write port, one read port with registered read data.
// Depends on no package.
`default_nettype none
module gdcr_map_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [2:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [2:0]    o_rdata
);
    logic [2:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> design/gdcr_div.sv
// Restoring divider giving one quotient bit per cycle.
// Depends on no package.
`default_nettype none
module gdcr_div #(
    parameter int N_W = 40,
    parameter int D_W = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_num,
    input  wire logic [D_W-1:0] i_den,
    output logic                o_done,
    output logic      [N_W-1:0] o_quot
);
    localparam int CW = $clog2(N_W + 1);

    logic [N_W-1:0] r_n;
    logic [D_W-1:0] r_rem;
    logic [D_W-1:0] r_den;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [D_W:0]   rem_sh;
    logic           ge;
    logic [D_W:0]   diff;

    assign rem_sh = {r_rem, r_n[N_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_n   <= {r_n[N_W-2:0], ge};
            r_rem <= ge ? diff[D_W-1:0] : rem_sh[D_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_n;
endmodule
`default_nettype wire
